/* rtl/core/msp_pkg.sv */
// shared types, codes and default sizes for the multi-stack shared pool unit
package msp_pkg;

    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 2;
    localparam int STACK_ID_W       = 2;
    localparam int DEF_NUM_STACKS   = 3;
    localparam int DEF_POOL_DEPTH   = 64;

    // operation codes carried on the input func field
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_EMPTY  = 2'd1,
        STS_FULL   = 2'd2,
        STS_BAD_ID = 2'd3
    } t_status;

    // work decided at accept time, applied once the node read returns
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH_FREE,
        OP_PUSH_NEW,
        OP_POP
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

/* rtl/core/msp_node_ram.sv */
// node pool memory: one write port, one read port with registered read data
module msp_node_ram #(
    parameter int DEPTH  = msp_pkg::DEF_POOL_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int WORD_W = msp_pkg::VALUE_W + ADDR_W + 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/multi_stack_shared_pool_unit.sv */
// multi-stack shared pool unit: several lifo stacks drawing nodes from one shared pool
//
// Each input item is a push or a pop on one of NUM_STACKS stacks. A push takes
// the head of the free list, or else the next never-used node, stores the value
// and links the node above the stack's old top. A pop hands back the top value
// and returns its node to the free list. Every item gives exactly one result
// item carrying the popped value (zero unless a pop succeeds) and a status:
// ok, stack empty, pool full or bad stack number. The accept cycle issues the
// read of the node memory, and the execute state uses the registered read data
// and writes back node, top pointer and free list. The result sits in an output
// register, so a new item is taken while an earlier result still waits; the
// unit only holds in its execute state when that register is full and not being
// drained. No clearing pass is needed after reset: node entries are only read
// once written, and top pointers and the free list head reset to null.
module multi_stack_shared_pool_unit #(
    parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
    parameter int POOL_DEPTH = msp_pkg::DEF_POOL_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [7:0]  i_s_axis_tuser,   // [0] func, [2:1] stack_id, rest zero
    // result item stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] popped_value
    output logic [7:0]  o_m_axis_tuser    // [1:0] status, rest zero
);

    localparam int ADDR_W    = $clog2(POOL_DEPTH);
    localparam int CNT_W     = $clog2(POOL_DEPTH + 1);
    localparam int SID_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int PTR_W     = ADDR_W + 1;
    localparam int VALUE_W   = msp_pkg::VALUE_W;
    localparam int WORD_W    = VALUE_W + PTR_W;

    // node pointer with a valid bit; a clear valid bit is the null marker
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
    } t_node_ptr;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    msp_pkg::t_state    r_state, n_state;
    t_node_ptr          r_top [NUM_STACKS];
    t_node_ptr          r_free_head;
    logic [CNT_W-1:0]   r_unused_next;

    // item in flight, captured at accept
    msp_pkg::t_op       r_op;
    msp_pkg::t_status   r_status;
    logic [SID_IDX_W-1:0] r_sid;
    logic [VALUE_W-1:0] r_value;
    logic [ADDR_W-1:0]  r_addr;

    // result register
    logic               r_m_tvalid;
    logic [VALUE_W-1:0] r_m_tdata;
    msp_pkg::t_status   r_m_status;

    // ------------------------------------------------------------------
    // input decode and decision, taken against the state at accept
    // ------------------------------------------------------------------
    logic                                in_func;
    logic [msp_pkg::STACK_ID_W-1:0]      in_sid;
    logic                                sid_ok;
    logic [SID_IDX_W-1:0]                sid_idx;
    t_node_ptr                           top_sel;
    msp_pkg::t_op                        dec_op;
    msp_pkg::t_status                    dec_status;
    logic [ADDR_W-1:0]                   dec_addr;

    assign in_func = i_s_axis_tuser[0];
    assign in_sid  = i_s_axis_tuser[2:1];
    assign sid_ok  = int'(in_sid) < NUM_STACKS;
    assign sid_idx = SID_IDX_W'(in_sid);
    assign top_sel = sid_ok ? r_top[sid_idx] : '0;

    always_comb begin
        dec_op     = msp_pkg::OP_NONE;
        dec_status = msp_pkg::STS_OK;
        dec_addr   = top_sel.idx;
        if (!sid_ok) begin
            dec_status = msp_pkg::STS_BAD_ID;
        end else if (in_func == msp_pkg::FUNC_PUSH) begin
            if (r_free_head.valid) begin
                dec_op   = msp_pkg::OP_PUSH_FREE;
                dec_addr = r_free_head.idx;
            end else if (r_unused_next != CNT_W'(POOL_DEPTH)) begin
                dec_op   = msp_pkg::OP_PUSH_NEW;
                dec_addr = r_unused_next[ADDR_W-1:0];
            end else begin
                dec_status = msp_pkg::STS_FULL;
            end
        end else begin
            if (top_sel.valid) begin
                dec_op = msp_pkg::OP_POP;
            end else begin
                dec_status = msp_pkg::STS_EMPTY;
            end
        end
    end

    // ------------------------------------------------------------------
    // control: accept in idle, finish once the result register has room
    // ------------------------------------------------------------------
    logic s_tready;
    logic in_accept;
    logic out_free;
    logic exec_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        s_tready  = 1'b0;
        exec_done = 1'b0;
        out_free  = !r_m_tvalid || i_m_axis_tready;
        case (r_state)
            msp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = msp_pkg::ST_EXEC;
                end
            end
            msp_pkg::ST_EXEC: begin
                if (out_free) begin
                    exec_done = 1'b1;
                    n_state   = msp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = msp_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_accept = i_s_axis_tvalid && s_tready;

    // ------------------------------------------------------------------
    // node memory: value in the upper bits, link pointer below
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;
    logic [VALUE_W-1:0] rd_value;
    t_node_ptr         rd_link;
    logic [VALUE_W-1:0] wr_value;
    t_node_ptr         wr_link;

    assign rd_value = ram_rdata[WORD_W-1 -: VALUE_W];
    assign rd_link  = t_node_ptr'(ram_rdata[PTR_W-1:0]);

    assign ram_re = in_accept
        && (dec_op == msp_pkg::OP_PUSH_FREE || dec_op == msp_pkg::OP_POP);
    assign ram_we = exec_done && (r_op != msp_pkg::OP_NONE);

    // a pop keeps the value and points the freed node at the old free head
    always_comb begin
        if (r_op == msp_pkg::OP_POP) begin
            wr_value = rd_value;
            wr_link  = r_free_head;
        end else begin
            wr_value = r_value;
            wr_link  = r_top[r_sid];
        end
    end

    assign ram_wdata = {wr_value, wr_link};

    msp_node_ram #(
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (ADDR_W),
        .WORD_W (WORD_W)
    ) u_msp_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (dec_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // capture of the item in flight
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= msp_pkg::OP_NONE;
        end else if (in_accept) begin
            r_op <= dec_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status <= dec_status;
            r_sid    <= sid_idx;
            r_value  <= i_s_axis_tdata;
            r_addr   <= dec_addr;
        end
    end

    // ------------------------------------------------------------------
    // write-back of top pointers, free list and never-used counter
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_top[i] <= '0;
            end
            r_free_head   <= '0;
            r_unused_next <= '0;
        end else if (exec_done) begin
            case (r_op)
                msp_pkg::OP_PUSH_FREE: begin
                    r_free_head  <= rd_link;
                    r_top[r_sid] <= '{valid: 1'b1, idx: r_addr};
                end
                msp_pkg::OP_PUSH_NEW: begin
                    r_unused_next <= r_unused_next + CNT_W'(1);
                    r_top[r_sid]  <= '{valid: 1'b1, idx: r_addr};
                end
                msp_pkg::OP_POP: begin
                    r_top[r_sid] <= rd_link;
                    r_free_head  <= '{valid: 1'b1, idx: r_addr};
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (exec_done) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_m_tdata  <= (r_op == msp_pkg::OP_POP) ? rd_value : '0;
            r_m_status <= r_status;
        end
    end

    assign o_s_axis_tready = s_tready;
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = {6'b0, r_m_status};

endmodule

/* rtl/core/msp_checker.sv */
// port-level checks for the multi-stack shared pool unit, with its bind
module msp_checker #(
    parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic [7:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [7:0]  o_m_axis_tuser
);

    logic in_acc;
    logic in_bad_id;

    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_bad_id = int'(i_s_axis_tuser[2:1]) >= NUM_STACKS;

    // one item in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("item accepted while another is in flight");

    // a result with a failing status carries a zero value
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] != msp_pkg::STS_OK
            |-> o_m_axis_tdata == '0)
        else $error("nonzero value with a failing status");

    // a bad stack number accepted while the output is empty is reported once the item completes
    a_bad_id_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_bad_id && !o_m_axis_tvalid
            |=> ##1 (o_m_axis_tvalid && o_m_axis_tuser[1:0] == msp_pkg::STS_BAD_ID))
        else $error("bad stack number not reported");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
            |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // an offered item holds until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready
            |=> i_s_axis_tvalid && $stable(i_s_axis_tdata) && $stable(i_s_axis_tuser))
        else $error("offered item changed before accept");

endmodule

bind multi_stack_shared_pool_unit msp_checker #(
    .NUM_STACKS (NUM_STACKS)
) u_msp_checker (.*);
